// ===== sv/i2cmts_pkg.sv =====
// Shared types and codes for the I2C master transaction sequencer.
package i2cmts_pkg;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_START = 2'd1,
        MODE_EVENT = 2'd2,
        MODE_NACK  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        OP_WRITE      = 2'd0,
        OP_READ       = 2'd1,
        OP_WRITE_READ = 2'd2,
        OP_INVALID    = 2'd3
    } op_t;

    typedef struct packed {
        mode_t       mode;
        logic [4:0]  index;
        logic [7:0]  data_byte;
        logic [6:0]  dev_addr;
        op_t         op;
        logic [5:0]  tx_len;
        logic [5:0]  rx_len;
        logic        flag_sb;
        logic        flag_addr;
        logic        flag_btf;
        logic        flag_txe;
        logic        flag_rxne;
    } item_t;

    typedef struct packed {
        logic        send_valid;
        logic [7:0]  out_byte;
        logic        rx_valid;
        logic [4:0]  rx_index;
        logic        start_req;
        logic        stop_req;
        logic        ack_enable;
        logic        buf_irq_enable;
        logic        busy_res;
        logic        failed;
        logic [5:0]  tx_count;
        logic [5:0]  rx_count;
    } result_t;

    // Sequencer control state.
    typedef struct packed {
        logic [6:0]  addr;
        op_t         op;
        logic [5:0]  tx_len;
        logic [5:0]  rx_len;
        logic [5:0]  tx_pos;
        logic [5:0]  rx_pos;
        logic        last_written;
        logic        tx_phase;
        logic        rx_phase;
        logic        error_mark;
        logic        ack_mark;
        logic        bufen_mark;
    } seq_state_t;

endpackage

// ===== sv/i2cmts_buf.sv =====
// Transmit byte buffer: one write port, one registered write-first read port.
module i2cmts_buf #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);
    logic [7:0] mem [0:DEPTH-1];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Same-cycle write to the read address is forwarded.
    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/i2cmts_step.sv =====
// Next-state and result logic for one sequencer transaction.
module i2cmts_step #(
    parameter int BUF_DEPTH = 32
) (
    input  i2cmts_pkg::seq_state_t st,
    input  i2cmts_pkg::item_t      item,
    input  logic [7:0]             tx_byte,
    output i2cmts_pkg::seq_state_t st_next,
    output i2cmts_pkg::result_t    res
);
    import i2cmts_pkg::*;

    function automatic logic [5:0] clamp_len(input logic [5:0] v);
        logic [8:0] ext;
        ext = {3'b000, v};
        return (ext > 9'(BUF_DEPTH)) ? 6'(BUF_DEPTH) : v;
    endfunction

    // End of transaction, normal or aborted.
    function automatic seq_state_t finish(input seq_state_t s, input logic err);
        seq_state_t f;
        f = s;
        if (err)
        begin
            f.error_mark = 1'b1;
        end
        f.bufen_mark   = 1'b0;
        f.tx_phase     = 1'b0;
        f.rx_phase     = 1'b0;
        f.last_written = 1'b0;
        return f;
    endfunction

    always_comb
    begin
        seq_state_t n;
        result_t    r;
        logic       done;
        logic [5:0] rx_len_c;
        logic [5:0] pos_inc;

        n        = st;
        r        = '0;
        done     = 1'b0;
        rx_len_c = clamp_len(item.rx_len);
        pos_inc  = 6'd0;

        case (item.mode)
            MODE_LOAD:
            begin
                // buffer write handled at the top level
            end
            MODE_START:
            begin
                if (!st.tx_phase && !st.rx_phase)
                begin
                    n.addr         = item.dev_addr;
                    n.op           = item.op;
                    n.tx_len       = clamp_len(item.tx_len);
                    n.rx_len       = rx_len_c;
                    n.error_mark   = 1'b0;
                    n.last_written = 1'b0;
                    n.tx_pos       = 6'd0;
                    n.rx_pos       = 6'd0;
                    if (item.op == OP_WRITE || item.op == OP_WRITE_READ)
                    begin
                        n.tx_phase = 1'b1;
                        n.rx_phase = 1'b0;
                    end
                    else if (item.op == OP_READ)
                    begin
                        n.tx_phase = 1'b0;
                        n.rx_phase = 1'b1;
                        if (rx_len_c > 6'd1)
                        begin
                            n.ack_mark = 1'b1;
                        end
                    end
                    r.start_req = 1'b1;
                end
            end
            MODE_NACK:
            begin
                n          = finish(n, 1'b1);
                r.stop_req = 1'b1;
            end
            MODE_EVENT:
            begin
                if (item.flag_sb)
                begin
                    if (st.tx_phase && !st.rx_phase)
                    begin
                        r.send_valid = 1'b1;
                        r.out_byte   = {st.addr, 1'b0};
                    end
                    else if (st.rx_phase && !st.tx_phase)
                    begin
                        r.send_valid = 1'b1;
                        r.out_byte   = {st.addr, 1'b1};
                    end
                    else
                    begin
                        n          = finish(n, 1'b1);
                        r.stop_req = 1'b1;
                    end
                end
                else
                begin
                    if (item.flag_addr)
                    begin
                        n.bufen_mark = 1'b1;
                    end
                    if (item.flag_btf && st.last_written)
                    begin
                        n.tx_phase     = 1'b0;
                        n.last_written = 1'b0;
                        if (st.op == OP_WRITE)
                        begin
                            n          = finish(n, 1'b0);
                            r.stop_req = 1'b1;
                        end
                        else if (st.op == OP_WRITE_READ && st.rx_len != 6'd0)
                        begin
                            // repeated start into the read phase
                            if (st.rx_len > 6'd1)
                            begin
                                n.ack_mark = 1'b1;
                            end
                            n.rx_phase   = 1'b1;
                            n.bufen_mark = 1'b0;
                            r.start_req  = 1'b1;
                        end
                        else
                        begin
                            n          = finish(n, 1'b1);
                            r.stop_req = 1'b1;
                        end
                        done = 1'b1;
                    end
                    if (!done && item.flag_txe && n.tx_phase && !n.rx_phase)
                    begin
                        if (n.tx_pos < n.tx_len && {3'b000, n.tx_pos} < 9'(BUF_DEPTH))
                        begin
                            r.send_valid = 1'b1;
                            r.out_byte   = tx_byte;
                            pos_inc      = n.tx_pos + 6'd1;
                            n.tx_pos     = pos_inc;
                            if (pos_inc == n.tx_len)
                            begin
                                n.last_written = 1'b1;
                            end
                        end
                        else
                        begin
                            n          = finish(n, 1'b0);
                            r.stop_req = 1'b1;
                        end
                    end
                    if (!done && item.flag_rxne && n.rx_phase && !n.tx_phase)
                    begin
                        if (n.rx_pos < n.rx_len)
                        begin
                            r.rx_valid = 1'b1;
                            r.out_byte = item.data_byte;
                            r.rx_index = n.rx_pos[4:0];
                            pos_inc    = n.rx_pos + 6'd1;
                            n.rx_pos   = pos_inc;
                            // NACK the last byte
                            if ((n.rx_len - pos_inc) == 6'd1)
                            begin
                                n.ack_mark = 1'b0;
                            end
                            if (pos_inc == n.rx_len)
                            begin
                                n          = finish(n, 1'b0);
                                r.stop_req = 1'b1;
                            end
                        end
                        else
                        begin
                            n          = finish(n, 1'b1);
                            r.stop_req = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase

        r.ack_enable     = n.ack_mark;
        r.buf_irq_enable = n.bufen_mark;
        r.busy_res       = n.tx_phase | n.rx_phase;
        r.failed         = n.error_mark;
        r.tx_count       = n.tx_pos;
        r.rx_count       = n.rx_pos;

        st_next = n;
        res     = r;
    end

endmodule

// ===== sv/i2c_master_transaction_sequencer_unit.sv =====
// I2C master transaction sequencer: top level with input, state and result registers.
// Sequences one I2C master transaction (write, read, or write then read with a
// repeated start) on top of a byte-level bus engine. Each accepted transaction
// on the item channel yields exactly one transaction on the result channel
// that carries any byte to send or byte received plus the current status.
// An accepted item lands in an input register; once the result register is
// free or being emptied, the step logic updates the sequencer state and
// loads the result register from the input register, and the block takes one
// item every cycle as long as results are taken. A stalled result holds the
// pipe; items are still accepted until the input register is full too.
// Transmit bytes live in a BUF_DEPTH-entry buffer whose registered read port
// is addressed by the next transmit position, so a data byte is ready when the
// transmit-empty event arrives. Buffer entries have no reset; sending an
// entry that was never loaded gives an undefined byte. Loads at an index at
// or above BUF_DEPTH are dropped, and lengths above BUF_DEPTH saturate.
module i2c_master_transaction_sequencer_unit #(
    parameter int BUF_DEPTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  i2cmts_pkg::item_t   item,
    output logic                result_valid,
    input  logic                result_ready,
    output i2cmts_pkg::result_t result
);
    import i2cmts_pkg::*;

    localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

    // input register
    item_t      item_reg;
    logic       item_valid_reg;

    // sequencer state
    seq_state_t state_reg;
    seq_state_t state_next;
    seq_state_t step_state;

    // result register
    result_t    result_reg;
    result_t    step_result;
    logic       result_valid_reg;

    logic       advance;
    logic       item_take;

    // buffer port
    logic          buf_wr_en;
    logic [8:0]    wr_idx_ext;
    logic [8:0]    rd_pos_ext;
    logic [AW-1:0] buf_wr_addr;
    logic [AW-1:0] buf_rd_addr;
    logic [7:0]    buf_rd_data;

    // Step fires when the input register holds a transaction and the result
    // register is free or being emptied this cycle.
    assign advance    = item_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready = !item_valid_reg || advance;
    assign item_take  = item_valid && item_ready;

    assign state_next = advance ? step_state : state_reg;

    i2cmts_step #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_step (
        .st      (state_reg),
        .item    (item_reg),
        .tx_byte (buf_rd_data),
        .st_next (step_state),
        .res     (step_result)
    );

    // Loads write the buffer; the read port tracks the next transmit position.
    assign wr_idx_ext  = {4'b0000, item_reg.index};
    assign rd_pos_ext  = {3'b000, state_next.tx_pos};
    assign buf_wr_en   = advance && (item_reg.mode == MODE_LOAD)
                         && (wr_idx_ext < 9'(BUF_DEPTH));
    assign buf_wr_addr = wr_idx_ext[AW-1:0];
    assign buf_rd_addr = rd_pos_ext[AW-1:0];

    i2cmts_buf #(
        .DEPTH (BUF_DEPTH),
        .AW    (AW)
    ) u_buf (
        .clk     (clk),
        .wr_en   (buf_wr_en),
        .wr_addr (buf_wr_addr),
        .wr_data (item_reg.data_byte),
        .rd_addr (buf_rd_addr),
        .rd_data (buf_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            state_reg        <= '0;
        end
        else
        begin
            if (item_ready)
            begin
                item_valid_reg <= item_valid;
            end
            if (advance)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            item_reg <= item;
        end
        if (advance)
        begin
            result_reg <= step_result;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== sv/i2cmts_checker.sv =====
// Port-level checker for the I2C master transaction sequencer, with its bind.
module i2cmts_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                result_valid,
    input logic                result_ready,
    input i2cmts_pkg::result_t result
);
    import i2cmts_pkg::*;

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // A result never carries both a byte to send and a received byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.send_valid && result.rx_valid))
        else $error("send and receive in one result");

    // Received byte index trails the updated receive count by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.rx_valid
            |-> {1'b0, result.rx_index} == (result.rx_count - 6'd1))
        else $error("receive index out of step with count");

    // A start never comes with a stop or a failure.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.start_req |-> !result.stop_req && !result.failed)
        else $error("start with stop or failure");

    // No byte: out_byte is zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.send_valid && !result.rx_valid
            |-> result.out_byte == 8'd0)
        else $error("stray out_byte");

endmodule

bind i2c_master_transaction_sequencer_unit i2cmts_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

// ===== sim/tb_top.sv =====
// Self-checking testbench for the I2C master transaction sequencer.
module tb_top;

    import i2cmts_pkg::*;

    localparam int BUF_ENTRIES   = 32;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 106;

    // Status flag masks for event_item: {sb, addr, btf, txe, rxne}
    localparam logic [4:0] EV_NONE = 5'b00000;
    localparam logic [4:0] EV_SB   = 5'b10000;
    localparam logic [4:0] EV_ADDR = 5'b01000;
    localparam logic [4:0] EV_BTF  = 5'b00100;
    localparam logic [4:0] EV_TXE  = 5'b00010;
    localparam logic [4:0] EV_RXNE = 5'b00001;

    logic    clk          = 1'b0;
    logic    rst_n        = 1'b0;
    logic    item_valid   = 1'b0;
    logic    item_ready;
    item_t   item         = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;

    i2c_master_transaction_sequencer_unit #(
        .BUF_DEPTH(BUF_ENTRIES)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Sequencer mirror: our own copy of the control state and tx buffer.
    // ------------------------------------------------------------------
    logic [6:0] seq_addr;
    op_t        seq_op;
    logic [5:0] seq_tx_len;
    logic [5:0] seq_rx_len;
    logic [5:0] seq_tx_pos;
    logic [5:0] seq_rx_pos;
    bit         seq_last;
    bit         seq_tx_phase;
    bit         seq_rx_phase;
    bit         seq_error;
    bit         seq_ack;
    bit         seq_bufen;
    logic [7:0] tx_bytes  [BUF_ENTRIES];
    bit         tx_loaded [BUF_ENTRIES];

    initial
    begin
        seq_addr     = '0;
        seq_op       = OP_WRITE;
        seq_tx_len   = '0;
        seq_rx_len   = '0;
        seq_tx_pos   = '0;
        seq_rx_pos   = '0;
        seq_last     = 1'b0;
        seq_tx_phase = 1'b0;
        seq_rx_phase = 1'b0;
        seq_error    = 1'b0;
        seq_ack      = 1'b0;
        seq_bufen    = 1'b0;
    end

    // Predicted bus answers, oldest first, one per accepted transaction.
    result_t answer_q [$];

    int unsigned fault_count    = 0;
    int unsigned cycle_count    = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    // Lengths above the buffer size saturate.
    function automatic logic [5:0] clip_len(input logic [5:0] n);
        return (n > 6'(BUF_ENTRIES)) ? 6'(BUF_ENTRIES) : n;
    endfunction

    // Common tail of an abort or a normal end; caller raises stop.
    function automatic void end_transfer(input bit err);
        if (err)
        begin
            seq_error = 1'b1;
        end
        seq_bufen    = 1'b0;
        seq_tx_phase = 1'b0;
        seq_rx_phase = 1'b0;
        seq_last     = 1'b0;
    endfunction

    // Advance the mirror by one transaction and return the expected answer.
    function automatic result_t sequence_step(input item_t it);
        result_t r;
        bit      done;
        r    = '0;
        done = 1'b0;
        case (it.mode)
            MODE_LOAD:
            begin
                tx_bytes[it.index]  = it.data_byte;
                tx_loaded[it.index] = 1'b1;
            end
            MODE_START:
            begin
                // a start while a phase is active only reports status
                if (!seq_tx_phase && !seq_rx_phase)
                begin
                    seq_addr   = it.dev_addr;
                    seq_op     = it.op;
                    seq_tx_len = clip_len(it.tx_len);
                    seq_rx_len = clip_len(it.rx_len);
                    seq_error  = 1'b0;
                    seq_last   = 1'b0;
                    seq_tx_pos = '0;
                    seq_rx_pos = '0;
                    case (seq_op)
                        OP_WRITE, OP_WRITE_READ:
                        begin
                            seq_tx_phase = 1'b1;
                            seq_rx_phase = 1'b0;
                        end
                        OP_READ:
                        begin
                            seq_tx_phase = 1'b0;
                            seq_rx_phase = 1'b1;
                            if (seq_rx_len > 6'd1)
                            begin
                                seq_ack = 1'b1;
                            end
                        end
                        default:
                        begin
                            // invalid op: start goes out, no phase entered
                        end
                    endcase
                    r.start_req = 1'b1;
                end
            end
            MODE_NACK:
            begin
                end_transfer(1'b1);
                r.stop_req = 1'b1;
            end
            default:
            begin
                if (it.flag_sb)
                begin
                    // start sent: address with direction, or abort if no phase
                    if (seq_tx_phase && !seq_rx_phase)
                    begin
                        r.send_valid = 1'b1;
                        r.out_byte   = {seq_addr, 1'b0};
                    end
                    else if (seq_rx_phase && !seq_tx_phase)
                    begin
                        r.send_valid = 1'b1;
                        r.out_byte   = {seq_addr, 1'b1};
                    end
                    else
                    begin
                        end_transfer(1'b1);
                        r.stop_req = 1'b1;
                    end
                end
                else
                begin
                    if (it.flag_addr)
                    begin
                        seq_bufen = 1'b1;
                    end
                    // byte finished after the last data byte ends the write phase
                    if (it.flag_btf && seq_last)
                    begin
                        seq_tx_phase = 1'b0;
                        seq_last     = 1'b0;
                        if (seq_op == OP_WRITE)
                        begin
                            end_transfer(1'b0);
                            r.stop_req = 1'b1;
                        end
                        else if (seq_op == OP_WRITE_READ && seq_rx_len > 6'd0)
                        begin
                            // repeated start into the read phase
                            if (seq_rx_len > 6'd1)
                            begin
                                seq_ack = 1'b1;
                            end
                            seq_rx_phase = 1'b1;
                            seq_bufen    = 1'b0;
                            r.start_req  = 1'b1;
                        end
                        else
                        begin
                            end_transfer(1'b1);
                            r.stop_req = 1'b1;
                        end
                        done = 1'b1;
                    end
                    if (!done && it.flag_txe && seq_tx_phase && !seq_rx_phase)
                    begin
                        if (seq_tx_pos < seq_tx_len)
                        begin
                            r.send_valid = 1'b1;
                            r.out_byte   = tx_bytes[seq_tx_pos[4:0]];
                            seq_tx_pos   = seq_tx_pos + 6'd1;
                            if (seq_tx_pos == seq_tx_len)
                            begin
                                seq_last = 1'b1;
                            end
                        end
                        else
                        begin
                            end_transfer(1'b0);
                            r.stop_req = 1'b1;
                        end
                    end
                    if (!done && it.flag_rxne && seq_rx_phase && !seq_tx_phase)
                    begin
                        if (seq_rx_pos < seq_rx_len)
                        begin
                            r.rx_valid = 1'b1;
                            r.out_byte = it.data_byte;
                            r.rx_index = seq_rx_pos[4:0];
                            seq_rx_pos = seq_rx_pos + 6'd1;
                            // NACK the final byte
                            if (seq_rx_len - seq_rx_pos == 6'd1)
                            begin
                                seq_ack = 1'b0;
                            end
                            if (seq_rx_pos == seq_rx_len)
                            begin
                                end_transfer(1'b0);
                                r.stop_req = 1'b1;
                            end
                        end
                        else
                        begin
                            // receive-full with nothing expected
                            end_transfer(1'b1);
                            r.stop_req = 1'b1;
                        end
                    end
                end
            end
        endcase
        r.ack_enable     = seq_ack;
        r.buf_irq_enable = seq_bufen;
        r.busy_res       = seq_tx_phase || seq_rx_phase;
        r.failed         = seq_error;
        r.tx_count       = seq_tx_pos;
        r.rx_count       = seq_rx_pos;
        return r;
    endfunction

    // True when the item would send a buffer entry that was never loaded.
    function automatic bit reads_unloaded(input item_t it);
        return it.mode == MODE_EVENT && !it.flag_sb && !(it.flag_btf && seq_last)
            && it.flag_txe && seq_tx_phase && !seq_rx_phase
            && seq_tx_pos < seq_tx_len && !tx_loaded[seq_tx_pos[4:0]];
    endfunction

    // ------------------------------------------------------------------
    // Item builders
    // ------------------------------------------------------------------
    function automatic item_t load_item(input logic [4:0] idx, input logic [7:0] data);
        item_t it;
        it           = '0;
        it.mode      = MODE_LOAD;
        it.index     = idx;
        it.data_byte = data;
        return it;
    endfunction

    function automatic item_t start_item(input logic [6:0] addr, input op_t op,
                                         input logic [5:0] txl, input logic [5:0] rxl);
        item_t it;
        it          = '0;
        it.mode     = MODE_START;
        it.dev_addr = addr;
        it.op       = op;
        it.tx_len   = txl;
        it.rx_len   = rxl;
        return it;
    endfunction

    function automatic item_t event_item(input logic [4:0] flags, input logic [7:0] data);
        item_t it;
        it           = '0;
        it.mode      = MODE_EVENT;
        it.data_byte = data;
        {it.flag_sb, it.flag_addr, it.flag_btf, it.flag_txe, it.flag_rxne} = flags;
        return it;
    endfunction

    function automatic item_t nack_item();
        item_t it;
        it      = '0;
        it.mode = MODE_NACK;
        return it;
    endfunction

    // Every field random, whatever the mode.
    function automatic item_t random_item();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return item_t'(raw[$bits(item_t)-1:0]);
    endfunction

    // Mostly short transfers; now and then any length up to the field max.
    function automatic logic [5:0] random_len();
        if ($urandom_range(0, 99) < 90)
        begin
            return 6'($urandom_range(0, 5));
        end
        return 6'($urandom_range(0, 63));
    endfunction

    // Next random item, steered by the mirror so most transfers run to the end.
    // Unused fields keep random values throughout.
    function automatic item_t next_bus_item();
        item_t       it;
        int unsigned pick;
        it   = random_item();
        pick = $urandom_range(0, 99);
        if (pick < 5)
        begin
            // raw noise
        end
        else if (!seq_tx_phase && !seq_rx_phase)
        begin
            if (pick < 40)
            begin
                it.mode  = MODE_LOAD;
                it.index = ($urandom_range(0, 1) == 0) ? 5'($urandom_range(0, 7))
                                                      : 5'($urandom_range(0, 31));
            end
            else if (pick < 44)
            begin
                it.mode = MODE_EVENT;
            end
            else
            begin
                it.mode   = MODE_START;
                it.op     = ($urandom_range(0, 19) == 0) ? OP_INVALID
                                                        : op_t'($urandom_range(0, 2));
                it.tx_len = random_len();
                it.rx_len = random_len();
            end
        end
        else
        begin
            it.mode = MODE_EVENT;
            {it.flag_sb, it.flag_addr, it.flag_btf, it.flag_txe, it.flag_rxne} = EV_NONE;
            if (pick < 8)
            begin
                it.mode = MODE_NACK;
            end
            else if (pick < 11)
            begin
                it.mode = MODE_START;    // start while busy
            end
            else if (pick < 19)
            begin
                it.flag_sb = 1'b1;
                {it.flag_addr, it.flag_btf, it.flag_txe, it.flag_rxne} =
                    4'($urandom_range(0, 15));
            end
            else if (pick < 27)
            begin
                it.flag_addr = 1'b1;
            end
            else if (seq_tx_phase)
            begin
                if (seq_last && pick < 75)
                begin
                    it.flag_btf = 1'b1;
                end
                else
                begin
                    it.flag_txe = 1'b1;
                end
            end
            else
            begin
                it.flag_rxne = 1'b1;
            end
            // occasional extra flags riding along
            if (it.mode == MODE_EVENT && !it.flag_sb && $urandom_range(0, 9) == 0)
            begin
                {it.flag_addr, it.flag_btf, it.flag_txe, it.flag_rxne} =
                    {it.flag_addr, it.flag_btf, it.flag_txe, it.flag_rxne}
                    | 4'($urandom_range(0, 15));
            end
        end
        // never send a buffer entry that was not loaded: load it instead
        if (reads_unloaded(it))
        begin
            it.mode  = MODE_LOAD;
            it.index = seq_tx_pos[4:0];
        end
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Sender: drive one transaction, then log its expected answer on
    // acceptance. Valid stays high into the next call when no gap follows.
    // ------------------------------------------------------------------
    task automatic send_transaction(input item_t it, input bit typed, input result_t want);
        result_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (!item_ready)
        begin
            @(posedge clk);
        end
        predicted = sequence_step(it);
        answer_q.push_back(typed ? want : predicted);
    endtask

    // Hold off the sender until every answer has come back.
    task automatic wait_for_answers();
        item_valid <= 1'b0;
        while (answer_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: check each accepted answer, then pick the next ready.
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fault_count++;
        end
    endtask

    result_t oldest;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                if (answer_q.size() == 0)
                begin
                    $error("result with no transaction outstanding");
                    fault_count++;
                end
                else
                begin
                    oldest = answer_q.pop_front();
                    check_field("send_valid",     oldest.send_valid,     result.send_valid);
                    check_field("out_byte",       oldest.out_byte,       result.out_byte);
                    check_field("rx_valid",       oldest.rx_valid,       result.rx_valid);
                    check_field("rx_index",       oldest.rx_index,       result.rx_index);
                    check_field("start_req",      oldest.start_req,      result.start_req);
                    check_field("stop_req",       oldest.stop_req,       result.stop_req);
                    check_field("ack_enable",     oldest.ack_enable,     result.ack_enable);
                    check_field("buf_irq_enable", oldest.buf_irq_enable, result.buf_irq_enable);
                    check_field("busy_res",       oldest.busy_res,       result.busy_res);
                    check_field("failed",         oldest.failed,         result.failed);
                    check_field("tx_count",       oldest.tx_count,       result.tx_count);
                    check_field("rx_count",       oldest.rx_count,       result.rx_count);
                end
            end
            result_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** i2c_master_transaction_sequencer_unit: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Directed table, then four random phases with different idling.
    // ------------------------------------------------------------------
    typedef struct {
        item_t   stim;
        bit      typed;
        result_t want;
    } plan_row_t;

    plan_row_t plan [$];

    function automatic void add_row(input item_t stim, input bit typed = 1'b0,
                                    input result_t want = '0);
        plan_row_t row;
        row.stim  = stim;
        row.typed = typed;
        row.want  = want;
        plan.push_back(row);
    endfunction

    initial
    begin
        int unsigned ph;
        int unsigned n;

        // Typed answers, field order:
        // send, byte, rxv, rxi, start, stop, ack, bufen, busy, failed, txc, rxc
        // abort straight out of reset: stop and failed only
        add_row(nack_item(), 1'b1,
                result_t'{1'b0, 8'h00, 1'b0, 5'd0, 1'b0, 1'b1, 1'b0, 1'b0,
                          1'b0, 1'b1, 6'd0, 6'd0});
        // loads at both buffer ends; failed stays set
        add_row(load_item(5'd0, 8'hFF), 1'b1,
                result_t'{1'b0, 8'h00, 1'b0, 5'd0, 1'b0, 1'b0, 1'b0, 1'b0,
                          1'b0, 1'b1, 6'd0, 6'd0});
        add_row(load_item(5'd31, 8'h00), 1'b1,
                result_t'{1'b0, 8'h00, 1'b0, 5'd0, 1'b0, 1'b0, 1'b0, 1'b0,
                          1'b0, 1'b1, 6'd0, 6'd0});
        // one-byte write to the top address; start clears failed
        add_row(start_item(7'h7F, OP_WRITE, 6'd1, 6'd0), 1'b1,
                result_t'{1'b0, 8'h00, 1'b0, 5'd0, 1'b1, 1'b0, 1'b0, 1'b0,
                          1'b1, 1'b0, 6'd0, 6'd0});
        // start while busy is ignored
        add_row(start_item(7'h00, OP_READ, 6'd3, 6'd3), 1'b1,
                result_t'{1'b0, 8'h00, 1'b0, 5'd0, 1'b0, 1'b0, 1'b0, 1'b0,
                          1'b1, 1'b0, 6'd0, 6'd0});
        // address byte with write direction
        add_row(event_item(EV_SB, 8'h00), 1'b1,
                result_t'{1'b1, 8'hFE, 1'b0, 5'd0, 1'b0, 1'b0, 1'b0, 1'b0,
                          1'b1, 1'b0, 6'd0, 6'd0});
        add_row(event_item(EV_ADDR | EV_TXE, 8'h00));
        add_row(event_item(EV_BTF, 8'h00));
        // plain read, rx length saturated, ACK armed at start
        add_row(start_item(7'h00, OP_READ, 6'd0, 6'd63));
        add_row(event_item(EV_SB, 8'h00));
        add_row(event_item(EV_RXNE, 8'hFF));
        add_row(nack_item());
        // invalid op, then start-sent aborts
        add_row(start_item(7'h2A, OP_INVALID, 6'd0, 6'd0));
        add_row(event_item(EV_SB, 8'h00));
        // write-read with nothing to read aborts after the write
        add_row(start_item(7'h55, OP_WRITE_READ, 6'd1, 6'd0));
        add_row(event_item(EV_SB, 8'h00));
        add_row(event_item(EV_TXE, 8'h00));
        add_row(event_item(EV_BTF, 8'h00));
        // receive-full with nothing expected
        add_row(start_item(7'h3C, OP_READ, 6'd0, 6'd0));
        add_row(event_item(EV_RXNE, 8'h5A));
        // write-read through the repeated start into the read
        add_row(start_item(7'h01, OP_WRITE_READ, 6'd1, 6'd2));
        add_row(event_item(EV_SB, 8'h00));
        add_row(event_item(EV_TXE, 8'h00));
        add_row(event_item(EV_BTF, 8'h00));
        add_row(event_item(EV_SB, 8'h00));
        add_row(event_item(EV_RXNE, 8'h00));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            send_transaction(plan[i].stim, plan[i].typed, plan[i].want);
        end
        wait_for_answers();

        // phase 0 none, 1 sender idle, 2 receiver stall, 3 both
        for (ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = (ph == 1) ? 66 : (ph == 3) ? 36 : 0;
            recv_stall_pct = (ph == 2) ? 66 : (ph == 3) ? 36 : 0;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                send_transaction(next_bus_item(), 1'b0, '0);
            end
            wait_for_answers();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fault_count == 0)
        begin
            $display("** i2c_master_transaction_sequencer_unit: PASSED **");
        end
        else
        begin
            $display("** i2c_master_transaction_sequencer_unit: FAILED **");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/i2cmts_pkg.sv
sv/i2cmts_buf.sv
sv/i2cmts_step.sv
sv/i2c_master_transaction_sequencer_unit.sv
sv/i2cmts_checker.sv
sim/tb_top.sv
